### design/pal_pkg.sv
// Shared types and codes of the positional array list.
package pal_pkg;

  // Operation codes carried in the kind field
  typedef enum logic [2:0] {
    OP_INSERT = 3'd0,
    OP_DELETE = 3'd1,
    OP_READ   = 3'd2,
    OP_WRITE  = 3'd3,
    OP_SEARCH = 3'd4
  } op_kind_e;

  // Result status codes
  typedef enum logic [1:0] {
    STS_DONE  = 2'd0,
    STS_FULL  = 2'd1,
    STS_RANGE = 2'd2
  } status_e;

  // Per-cycle command broadcast to every cell
  typedef struct packed {
    logic ins;  // shift up from the left neighbor, place word at position
    logic del;  // shift down from the right neighbor
    logic wr;   // overwrite the entry at position
    logic cmp;  // compare the held entry against the key
  } cell_ctl_t;

  // Search scan looks at this many match flags per cycle
  localparam int GRP_BITS = 3;
  localparam int GRP      = 1 << GRP_BITS;

  // Widths of the result fields
  localparam int COUNT_W = 7;
  localparam int FPOS_W  = 6;
  localparam int VALUE_W = 32;

endpackage

### design/pal_cell.sv
// One storage cell of the list: holds a single entry and its match flag.
module pal_cell #(
  parameter int WORD_BITS = 32,
  parameter int CW        = 7,
  parameter int IDX       = 0
) (
  input  logic                  clk_i,
  input  pal_pkg::cell_ctl_t    ctl_i,
  input  logic [CW-1:0]         pos_i,
  input  logic [CW-1:0]         cnt_i,
  input  logic [WORD_BITS-1:0]  word_i,
  input  logic [WORD_BITS-1:0]  left_i,
  input  logic [WORD_BITS-1:0]  right_i,
  output logic [WORD_BITS-1:0]  data_o,
  output logic                  match_o
);
  import pal_pkg::*;

  localparam logic [CW-1:0] IDX_C = CW'(IDX);

  logic [WORD_BITS-1:0] data_q, data_d;
  logic                 match_q;

  // Pick the next entry: shift up, place, shift down, overwrite or hold
  always_comb begin
    data_d = data_q;
    if (ctl_i.ins && (IDX_C > pos_i)) begin
      data_d = left_i;
    end else if (ctl_i.ins && (IDX_C == pos_i)) begin
      data_d = word_i;
    end else if (ctl_i.del && (IDX_C >= pos_i)) begin
      data_d = right_i;
    end else if (ctl_i.wr && (IDX_C == pos_i)) begin
      data_d = word_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  // Capture the compare against the key for entries in use
  always_ff @(posedge clk_i) begin
    if (ctl_i.cmp) begin
      match_q <= (IDX_C < cnt_i) && (data_q == word_i);
    end
  end

  assign data_o  = data_q;
  assign match_o = match_q;

endmodule

### design/pal_scan.sv
// Search scanner: walks the match flags a group per cycle to the lowest hit.
module pal_scan #(
  parameter int DEPTH = 64,
  parameter int CW    = 7,
  parameter int PW    = 6
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DEPTH-1:0] match_i,
  input  logic [CW-1:0]    cnt_i,
  output logic             done_o,
  output logic             found_o,
  output logic [PW-1:0]    pos_o
);
  import pal_pkg::*;

  localparam int NGRP = (DEPTH + GRP - 1) / GRP;
  localparam int GW   = (NGRP > 1) ? $clog2(NGRP) : 1;
  localparam int SW   = CW + GRP_BITS + 1;

  logic [NGRP*GRP-1:0]     match_pad;
  logic [GRP-1:0]          grp_bits;
  logic [GRP_BITS-1:0]     first;
  logic [GW+GRP_BITS-1:0]  hit_pos;
  logic [SW-1:0]           next_base;
  logic                    last_grp;
  logic [GW-1:0]           g_q;
  logic                    busy_q, done_q, found_q;
  logic [PW-1:0]           pos_q;

  assign match_pad = (NGRP*GRP)'(match_i);
  assign grp_bits  = match_pad[g_q*GRP +: GRP];

  // Find the lowest set flag of the current group
  always_comb begin
    first = '0;
    for (int b = GRP - 1; b >= 0; b--) begin
      if (grp_bits[b]) begin
        first = GRP_BITS'(b);
      end
    end
  end

  assign hit_pos   = {g_q, first};
  assign next_base = (SW'(g_q) + SW'(1)) << GRP_BITS;
  assign last_grp  = (g_q == GW'(NGRP - 1)) || (next_base >= SW'(cnt_i));

  // Advance one group per cycle until a hit or the end of the list
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      g_q     <= '0;
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
      found_q <= 1'b0;
      pos_q   <= '0;
    end else if (start_i) begin
      g_q     <= '0;
      busy_q  <= 1'b1;
      done_q  <= 1'b0;
      found_q <= 1'b0;
      pos_q   <= '0;
    end else if (busy_q) begin
      if (|grp_bits) begin
        found_q <= 1'b1;
        pos_q   <= PW'(hit_pos);
        done_q  <= 1'b1;
        busy_q  <= 1'b0;
      end else if (last_grp) begin
        done_q  <= 1'b1;
        busy_q  <= 1'b0;
      end else begin
        g_q <= g_q + GW'(1);
      end
    end
  end

  assign done_o  = done_q;
  assign found_o = found_q;
  assign pos_o   = pos_q;

endmodule

### design/positional_array_list.sv
// Positional array list top level: cell row, search scanner and result register.
//
// An ordered list of signed words with insert, delete, read, write and search
// by position. Each input word on kind_i/position_i/value_i yields one result
// word on read_value_o/found_o/found_position_o/count_o/status_o.
// Both channels move a word at a clock edge where valid is high and stall low.
// Insert, delete, read, write and unknown kinds finish at the accepting edge;
// the result is registered and shows in the cycle after, and a new word is taken
// every cycle as long as the receiver keeps up.
// Search registers a compare in every cell at the accepting edge, then the
// scanner checks eight match flags per cycle and stops at the first group with
// a hit or at the last group in use; the input stalls until the result is in
// the output register.
// Refused operations (full list, position out of range) change nothing.
// Reset empties the list (count zero); entry contents are not cleared.
// While the receiver stalls, the result holds and no new word is accepted
// once the output register is occupied.
module positional_array_list #(
  parameter int DEPTH     = 64,
  parameter int WORD_BITS = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [2:0]         kind_i,
  input  logic [6:0]         position_i,
  input  logic signed [31:0] value_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] read_value_o,
  output logic               found_o,
  output logic [5:0]         found_position_o,
  output logic [6:0]         count_o,
  output logic [1:0]         status_o
);
  import pal_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);
  localparam int PW = $clog2(DEPTH);
  localparam int XW = (CW > 7) ? CW : 7;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SCAN = 2'b10
  } state_e;

  state_e                state_q, state_d;
  logic [CW-1:0]         cnt_q, cnt_d;
  logic                  out_valid_q;
  logic [WORD_BITS-1:0]  rd_q;
  logic                  found_q;
  logic [PW-1:0]         fpos_q;
  logic [CW-1:0]         out_cnt_q;
  status_e               status_q;

  logic [WORD_BITS-1:0]  word;
  logic [WORD_BITS-1:0]  cell_data [DEPTH];
  logic [DEPTH-1:0]      match;
  logic [XW-1:0]         pos_x, cnt_x;
  logic [CW-1:0]         pos_c;
  logic                  accept, out_free, full;
  logic                  is_ins, is_del, is_rd, is_wr, is_srch;
  logic                  ins_ok, del_ok, rd_ok, wr_ok;
  cell_ctl_t             ctl;
  status_e               status_d;
  logic                  scan_done, scan_found;
  logic [PW-1:0]         scan_pos;
  logic                  load_op, load_srch;

  // Decode the incoming word
  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != ST_IDLE) || !out_free;
  assign accept     = in_valid_i && !in_stall_o;

  assign word  = WORD_BITS'(value_i);
  assign pos_x = XW'(position_i);
  assign cnt_x = XW'(cnt_q);
  assign pos_c = CW'(position_i);
  assign full  = (cnt_q == CW'(DEPTH));

  assign is_ins  = (kind_i == OP_INSERT);
  assign is_del  = (kind_i == OP_DELETE);
  assign is_rd   = (kind_i == OP_READ);
  assign is_wr   = (kind_i == OP_WRITE);
  assign is_srch = (kind_i == OP_SEARCH);

  assign ins_ok = is_ins && !full && (pos_x <= cnt_x);
  assign del_ok = is_del && (pos_x < cnt_x);
  assign rd_ok  = is_rd  && (pos_x < cnt_x);
  assign wr_ok  = is_wr  && (pos_x < cnt_x);

  // Broadcast the command to the cell row
  always_comb begin
    ctl.ins = accept && ins_ok;
    ctl.del = accept && del_ok;
    ctl.wr  = accept && wr_ok;
    ctl.cmp = accept && is_srch;
  end

  // Pick the status and the count after the operation
  always_comb begin
    status_d = STS_DONE;
    cnt_d    = cnt_q;
    if (is_ins) begin
      if (full) begin
        status_d = STS_FULL;
      end else if (pos_x > cnt_x) begin
        status_d = STS_RANGE;
      end
    end else if (is_del || is_rd || is_wr) begin
      if (pos_x >= cnt_x) begin
        status_d = STS_RANGE;
      end
    end
    if (ctl.ins) begin
      cnt_d = cnt_q + CW'(1);
    end else if (ctl.del) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  // Row of cells, each handing entries to its neighbors
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [WORD_BITS-1:0] left, right;
    if (i == 0) begin : g_first
      assign left = '0;
    end else begin : g_mid_l
      assign left = cell_data[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right = '0;
    end else begin : g_mid_r
      assign right = cell_data[i+1];
    end
    pal_cell #(
      .WORD_BITS (WORD_BITS),
      .CW        (CW),
      .IDX       (i)
    ) u_cell (
      .clk_i   (clk_i),
      .ctl_i   (ctl),
      .pos_i   (pos_c),
      .cnt_i   (cnt_q),
      .word_i  (word),
      .left_i  (left),
      .right_i (right),
      .data_o  (cell_data[i]),
      .match_o (match[i])
    );
  end

  pal_scan #(
    .DEPTH (DEPTH),
    .CW    (CW),
    .PW    (PW)
  ) u_scan (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (ctl.cmp),
    .match_i (match),
    .cnt_i   (cnt_q),
    .done_o  (scan_done),
    .found_o (scan_found),
    .pos_o   (scan_pos)
  );

  // Sequence a search through the scanner
  assign load_op   = accept && !is_srch;
  assign load_srch = (state_q == ST_SCAN) && scan_done && out_free;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && is_srch) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (load_srch) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        cnt_q <= cnt_d;
      end
      if (load_op || load_srch) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Load the result register
  always_ff @(posedge clk_i) begin
    if (load_op) begin
      rd_q      <= rd_ok ? cell_data[pos_c[PW-1:0]] : '0;
      found_q   <= 1'b0;
      fpos_q    <= '0;
      out_cnt_q <= cnt_d;
      status_q  <= status_d;
    end else if (load_srch) begin
      rd_q      <= '0;
      found_q   <= scan_found;
      fpos_q    <= scan_pos;
      out_cnt_q <= cnt_q;
      status_q  <= STS_DONE;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign read_value_o     = VALUE_W'(rd_q);
  assign found_o          = found_q;
  assign found_position_o = FPOS_W'(fpos_q);
  assign count_o          = COUNT_W'(out_cnt_q);
  assign status_o         = status_q;

endmodule

### tb/pal_checker.sv
// Checker for the positional array list: predicts each result word and compares it.
`timescale 1ns / 1ps

module pal_checker #(
  parameter int LIST_DEPTH = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic [2:0]         kind_i,
  input  logic [6:0]         position_i,
  input  logic signed [31:0] value_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic signed [31:0] read_value_i,
  input  logic               found_i,
  input  logic [5:0]         found_position_i,
  input  logic [6:0]         count_i,
  input  logic [1:0]         status_i,
  output int unsigned        pending_o,
  output int unsigned        fail_count_o
);
  import pal_pkg::*;

  typedef struct {
    logic signed [31:0] read_value;
    logic               found;
    logic [5:0]         found_position;
    logic [6:0]         count;
    status_e            status;
  } list_result_t;

  // Shadow copy of the list
  logic [31:0]  list_store [LIST_DEPTH];
  int unsigned  list_len;
  list_result_t result_q [$];

  // Print one mismatch and count it
  task automatic report_mismatch(input string msg);
    $display("%0t ns pal_checker: %s", $time, msg);
    fail_count_o++;
  endtask

  // Apply one operation to the shadow list and build the result word it gives
  function automatic list_result_t apply_to_list(input logic [2:0] kind,
                                                 input logic [6:0] pos,
                                                 input logic [31:0] word);
    list_result_t res;
    int unsigned  n;
    res.read_value     = '0;
    res.found          = 1'b0;
    res.found_position = '0;
    res.status         = STS_DONE;
    n = list_len;
    case (kind)
      OP_INSERT: begin
        if (n >= LIST_DEPTH) begin
          res.status = STS_FULL;
        end else if (pos > n) begin
          res.status = STS_RANGE;
        end else begin
          for (int unsigned i = n; i > pos; i--) list_store[i] = list_store[i-1];
          list_store[pos] = word;
          list_len = n + 1;
        end
      end
      OP_DELETE: begin
        if (pos >= n) begin
          res.status = STS_RANGE;
        end else begin
          for (int unsigned i = pos; i + 1 < n; i++) list_store[i] = list_store[i+1];
          list_len = n - 1;
        end
      end
      OP_READ: begin
        if (pos >= n) res.status = STS_RANGE;
        else res.read_value = list_store[pos];
      end
      OP_WRITE: begin
        if (pos >= n) res.status = STS_RANGE;
        else list_store[pos] = word;
      end
      OP_SEARCH: begin
        for (int unsigned i = 0; i < n; i++) begin
          if (list_store[i] == word) begin
            res.found          = 1'b1;
            res.found_position = i[5:0];
            break;
          end
        end
      end
      default: ;
    endcase
    res.count = list_len[6:0];
    return res;
  endfunction

  // Compare accepted result words first, then queue the prediction for an accepted input word
  always @(posedge clk_i or negedge rst_ni) begin
    list_result_t want;
    if (!rst_ni) begin
      list_len = 0;
      result_q.delete();
      pending_o = 0;
      fail_count_o = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (result_q.size() == 0) begin
          report_mismatch("result word with no prediction waiting");
        end else begin
          want = result_q.pop_front();
          if (read_value_i !== want.read_value)
            report_mismatch($sformatf("read_value got %h want %h",
                                      read_value_i, want.read_value));
          if (found_i !== want.found)
            report_mismatch($sformatf("found got %b want %b", found_i, want.found));
          if (found_position_i !== want.found_position)
            report_mismatch($sformatf("found_position got %0d want %0d",
                                      found_position_i, want.found_position));
          if (count_i !== want.count)
            report_mismatch($sformatf("count got %0d want %0d", count_i, want.count));
          if (status_i !== want.status)
            report_mismatch($sformatf("status got %0d want %0d", status_i, want.status));
        end
      end
      if (in_valid_i && !in_stall_i) begin
        result_q.push_back(apply_to_list(kind_i, position_i, value_i));
      end
      pending_o = result_q.size();
    end
  end

endmodule

### tb/tb_positional_array_list.sv
// Testbench top for the positional array list: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_positional_array_list;
  import pal_pkg::*;

  localparam int          LIST_DEPTH  = 64;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam logic [2:0]  KIND_SPARE_FIRST = 3'd5;
  localparam logic [2:0]  KIND_SPARE_LAST  = 3'd7;
  localparam logic [31:0] WORD_MIN = 32'h8000_0000;
  localparam logic [31:0] WORD_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] WORD_ONES = 32'hFFFF_FFFF;

  // Phase shapes for the random part
  typedef enum int {PH_GROW, PH_SHRINK, PH_MIXED} phase_e;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic [2:0]         kind;
  logic [6:0]         position;
  logic signed [31:0] value;
  logic               out_valid;
  logic               out_stall;
  logic signed [31:0] read_value;
  logic               found;
  logic [5:0]         found_position;
  logic [6:0]         count;
  logic [1:0]         status;

  int unsigned pending;
  int unsigned fail_count;
  int unsigned cycle_count;
  int unsigned list_len;
  int unsigned burst_left;
  int unsigned stall_mode;
  int unsigned stall_mode_left;

  positional_array_list #(
    .DEPTH(LIST_DEPTH),
    .WORD_BITS(32)
  ) u_top (
    .clk_i(clk),
    .rst_ni(rst_n),
    .in_valid_i(in_valid),
    .in_stall_o(in_stall),
    .kind_i(kind),
    .position_i(position),
    .value_i(value),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .read_value_o(read_value),
    .found_o(found),
    .found_position_o(found_position),
    .count_o(count),
    .status_o(status)
  );

  pal_checker #(
    .LIST_DEPTH(LIST_DEPTH)
  ) u_checker (
    .clk_i(clk),
    .rst_ni(rst_n),
    .in_valid_i(in_valid),
    .in_stall_i(in_stall),
    .kind_i(kind),
    .position_i(position),
    .value_i(value),
    .out_valid_i(out_valid),
    .out_stall_i(out_stall),
    .read_value_i(read_value),
    .found_i(found),
    .found_position_i(found_position),
    .count_i(count),
    .status_i(status),
    .pending_o(pending),
    .fail_count_o(fail_count)
  );

  // Drive the clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // End the run on timeout
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Stall the result channel in modes of random length
  always @(negedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_mode <= 0;
      stall_mode_left <= 0;
    end else begin
      if (stall_mode_left == 0) begin
        stall_mode <= $urandom_range(0, 3);
        stall_mode_left <= $urandom_range(16, 120);
      end else begin
        stall_mode_left <= stall_mode_left - 1;
      end
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        2: out_stall <= ($urandom_range(0, 3) != 0);
        default: out_stall <= (stall_mode_left % 3 == 0);
      endcase
    end
  end

  // Drop valid and hold it low while idling
  task automatic idle_cycles(input int unsigned n);
    repeat (n) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
  endtask

  // Hold off until every predicted result word has come back
  task automatic drain_results();
    idle_cycles(1);
    while (pending != 0) @(negedge clk);
  endtask

  // Send one word in bursts with random gaps, tracking the list length for shaping
  task automatic send_word(input logic [2:0] k, input logic [6:0] pos, input logic [31:0] v);
    if (burst_left == 0) begin
      idle_cycles($urandom_range(1, 7));
      burst_left = ($urandom_range(0, 7) == 0) ? 150 : $urandom_range(1, 20);
    end
    burst_left--;
    @(negedge clk);
    in_valid <= 1'b1;
    kind     <= k;
    position <= pos;
    value    <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (k == OP_INSERT && list_len < LIST_DEPTH && pos <= list_len) list_len++;
    if (k == OP_DELETE && pos < list_len) list_len--;
  endtask

  // Pick a word: small pool for search hits and duplicates, extremes, or anything
  function automatic logic [31:0] pick_word();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 40) return 32'($signed($urandom_range(0, 15)) - 8);
    if (r < 50) begin
      case ($urandom_range(0, 3))
        0: return WORD_MIN;
        1: return WORD_MAX;
        2: return WORD_ONES;
        default: return '0;
      endcase
    end
    return $urandom;
  endfunction

  // Pick a position: mostly in range, sometimes at the edge, past it, or anywhere
  function automatic logic [6:0] pick_position(input int unsigned span);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 80 && span > 0) return 7'($urandom_range(0, span - 1));
    if (r < 88) return 7'(span);
    if (r < 95) return 7'($urandom_range(span + 1 < 127 ? span + 1 : 127, 127 < span + 8 ? 127 : span + 8));
    return 7'($urandom_range(0, 127));
  endfunction

  // Random words shaped by phase: insert-heavy, delete-heavy or mixed
  task automatic run_phase(input phase_e ph, input int unsigned n);
    int unsigned ins_pct;
    int unsigned del_pct;
    int unsigned r;
    logic [2:0]  k;
    case (ph)
      PH_GROW:   begin ins_pct = 70; del_pct = 10; end
      PH_SHRINK: begin ins_pct = 10; del_pct = 62; end
      default:   begin ins_pct = 30; del_pct = 26; end
    endcase
    repeat (n) begin
      r = $urandom_range(0, 99);
      if (r < ins_pct) k = OP_INSERT;
      else if (r < ins_pct + del_pct) k = OP_DELETE;
      else if (r >= 97) k = 3'($urandom_range(KIND_SPARE_FIRST, KIND_SPARE_LAST));
      else begin
        case ($urandom_range(0, 2))
          0: k = OP_READ;
          1: k = OP_WRITE;
          default: k = OP_SEARCH;
        endcase
      end
      send_word(k, pick_position(k == OP_INSERT ? list_len + 1 : list_len), pick_word());
    end
  endtask

  initial begin
    in_valid    = 1'b0;
    kind        = '0;
    position    = '0;
    value       = '0;
    rst_n       = 1'b0;
    list_len    = 0;
    burst_left  = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Empty list: every positional operation out of range, search misses
    send_word(OP_READ, 7'd0, 32'd1);
    send_word(OP_DELETE, 7'd0, 32'd1);
    send_word(OP_WRITE, 7'd0, 32'd1);
    send_word(OP_SEARCH, 7'd0, 32'd0);
    send_word(OP_INSERT, 7'd1, 32'd3);
    // Build [-1, 0, MIN, MAX] through front, middle and append inserts
    send_word(OP_INSERT, 7'd0, WORD_MIN);
    send_word(OP_INSERT, 7'd1, WORD_MAX);
    send_word(OP_INSERT, 7'd0, WORD_ONES);
    send_word(OP_INSERT, 7'd1, 32'd0);
    send_word(OP_READ, 7'd0, 32'd0);
    send_word(OP_READ, 7'd3, 32'd0);
    send_word(OP_READ, 7'd4, 32'd0);
    send_word(OP_READ, 7'd127, 32'd0);
    send_word(OP_WRITE, 7'd3, 32'd5);
    send_word(OP_SEARCH, 7'd0, WORD_MIN);
    send_word(OP_SEARCH, 7'd127, 32'd5);
    send_word(OP_SEARCH, 7'd0, 32'h1234_5678);
    send_word(OP_DELETE, 7'd1, 32'd0);
    send_word(OP_DELETE, 7'd3, 32'd0);
    send_word(OP_DELETE, 7'd2, 32'd0);
    send_word(OP_INSERT, 7'd127, 32'd7);
    send_word(KIND_SPARE_FIRST, 7'd0, WORD_ONES);
    send_word(3'd6, 7'd127, WORD_MAX);
    send_word(KIND_SPARE_LAST, 7'd64, WORD_MIN);
    drain_results();

    // Random part: fill to full, empty out, and mix, pausing for a full drain after some phases
    run_phase(PH_GROW, 250);
    drain_results();
    run_phase(PH_SHRINK, 250);
    run_phase(PH_MIXED, 300);
    drain_results();
    run_phase(PH_GROW, 200);
    run_phase(PH_MIXED, 200);
    drain_results();
    run_phase(PH_SHRINK, 230);

    // Wait for the last result words, then give the block time to settle
    drain_results();
    repeat (16) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
